>>> src/histogram_statistics_collector_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the histogram statistics collector
// Concurrent checks are compiled for simulation and left empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef HISTOGRAM_STATISTICS_COLLECTOR_ASSERT_SVH
`define HISTOGRAM_STATISTICS_COLLECTOR_ASSERT_SVH
`ifndef SYNTHESIS
// check on every clock edge outside reset
`define HSC_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check on every clock edge, reset included
`define HSC_ASSERT_ANY(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HSC_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define HSC_ASSERT_ANY(lbl, clk, prop, msg)
`endif
`endif

>>> src/hsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsc_pkg
// Types and constants shared by the histogram statistics collector.
// ----------------------------------------------------------------------------
package hsc_pkg;

    // request codes
    localparam logic [1:0] REQ_ADD   = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_RANGE_START = 2'd0;
    localparam logic [1:0] CFG_BIN_WIDTH   = 2'd1;
    localparam logic [1:0] CFG_BINS_IN_USE = 2'd2;

    // widest bin address the design supports (4096 bins)
    localparam int MAX_BIN_BITS = 12;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] sample;
        logic [7:0]  read_bin;
    } t_req_item;

    typedef struct packed {
        logic [7:0]  bin_index;
        logic [31:0] bin_value;
        logic [31:0] sample_count;
        logic [63:0] value_sum;
        logic [63:0] square_sum;
        logic [31:0] min_value;
        logic [31:0] max_value;
    } t_res_item;

    typedef struct packed {
        logic [31:0] range_start;
        logic [31:0] bin_width;
        logic [8:0]  bins_in_use;
    } t_cfg;

    // classified request passed from front to back
    typedef struct packed {
        logic [1:0]              req_type;
        logic [31:0]             sample;
        logic [MAX_BIN_BITS-1:0] bin;
        logic [7:0]              out_idx;
        logic                    bin_ok;
    } t_cmd;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_DIV,
        FR_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        BK_CLR,
        BK_IDLE,
        BK_RD,
        BK_EXEC,
        BK_OUT
    } t_back_state;

endpackage

>>> src/hsc_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsc_fifo
// Two-entry flop queue decoupling producer and consumer.
// ----------------------------------------------------------------------------
module hsc_fifo #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_din,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_dout,
    output logic         o_empty
);

    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);

    logic [W-1:0] r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [PW:0]   r_cnt;
    logic          w_push;
    logic          w_pop;

    assign o_full  = (r_cnt == (PW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_dout  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wr <= r_wr + 1'b1;
            if (w_pop)  r_rd <= r_rd + 1'b1;
            if (w_push && !w_pop)      r_cnt <= r_cnt + 1'b1;
            else if (!w_push && w_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr] <= i_din;
    end

endmodule

>>> src/hsc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsc_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hsc_div #(
    parameter int DW = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [31:0]   i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quot
);

    localparam int CW = $clog2(DW + 1);

    logic [31:0]   r_rem;
    logic [DW-1:0] r_quot;
    logic [31:0]   r_div;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [32:0] w_trial;
    logic [32:0] w_sub;
    logic        w_ge;
    logic [31:0] n_rem;

    // one trial subtraction per step
    always_comb begin
        w_trial = {r_rem, r_quot[DW-1]};
        w_sub   = w_trial - {1'b0, r_div};
        w_ge    = (w_trial >= {1'b0, r_div});
        n_rem   = w_ge ? w_sub[31:0] : w_trial[31:0];
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: dividend bits shift out as quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quot <= i_dividend;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quot <= {r_quot[DW-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

>>> src/hsc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsc_front
// Accepts requests, masks the sample and works out the target bin.
// ----------------------------------------------------------------------------
module hsc_front #(
    parameter int NUM_BINS    = 256,
    parameter int SAMPLE_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hsc_pkg::t_cfg     i_cfg,
    input  logic              i_push,
    input  hsc_pkg::t_req_item i_req,
    output logic              o_full,
    output logic              o_cmd_push,
    output hsc_pkg::t_cmd     o_cmd,
    input  logic              i_cmd_full
);

    `include "histogram_statistics_collector_assert.svh"
    import hsc_pkg::*;

    localparam logic [31:0] SMASK = 32'((64'd1 << SAMPLE_BITS) - 64'd1);
    localparam logic [31:0] NB32  = 32'(NUM_BINS);

    t_front_state r_state;
    t_front_state n_state;
    t_cmd         r_cmd;
    t_cmd         w_cmd_in;

    logic [31:0]            w_v;
    logic [31:0]            w_diff;
    logic [31:0]            w_divisor;
    logic                   w_is_add;
    logic                   w_div_start;
    logic                   w_div_done;
    logic [SAMPLE_BITS-1:0] w_quot;
    logic [31:0]            w_quot32;
    logic [31:0]            w_biu32;
    logic [31:0]            w_nbins;
    logic [31:0]            w_idx;

    // sample masking and classification
    always_comb begin
        w_v       = i_req.sample & SMASK;
        w_diff    = w_v - i_cfg.range_start;
        w_divisor = (i_cfg.bin_width == '0) ? 32'd1 : i_cfg.bin_width;
        w_is_add  = (i_req.req_type == REQ_ADD);

        w_cmd_in.req_type = i_req.req_type;
        w_cmd_in.sample   = w_v;
        w_cmd_in.bin      = w_is_add ? '0 : MAX_BIN_BITS'(i_req.read_bin);
        w_cmd_in.out_idx  = (i_req.req_type == REQ_READ) ? i_req.read_bin : 8'd0;
        w_cmd_in.bin_ok   = (32'(i_req.read_bin) < NB32);
    end

    // clamp of the quotient to the bins in use
    always_comb begin
        w_biu32  = 32'(i_cfg.bins_in_use);
        if (w_biu32 == '0)       w_nbins = 32'd1;
        else if (w_biu32 > NB32) w_nbins = NB32;
        else                     w_nbins = w_biu32;
        w_quot32 = 32'(w_quot);
        w_idx    = (w_quot32 >= w_nbins) ? (w_nbins - 32'd1) : w_quot32;
    end

    hsc_div #(
        .DW (SAMPLE_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_diff[SAMPLE_BITS-1:0]),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // next state
    always_comb begin
        n_state     = r_state;
        w_div_start = 1'b0;
        o_cmd_push  = 1'b0;
        case (r_state)
            FR_IDLE: begin
                if (i_push) begin
                    if (w_is_add && (w_v >= i_cfg.range_start)) begin
                        w_div_start = 1'b1;
                        n_state     = FR_DIV;
                    end else begin
                        n_state = FR_PUSH;
                    end
                end
            end
            FR_DIV: begin
                if (w_div_done) n_state = FR_PUSH;
            end
            FR_PUSH: begin
                if (!i_cmd_full) begin
                    o_cmd_push = 1'b1;
                    n_state    = FR_IDLE;
                end
            end
            default: n_state = FR_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FR_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // command register
    always_ff @(posedge i_clk) begin
        if (r_state == FR_IDLE && i_push) begin
            r_cmd <= w_cmd_in;
        end else if (r_state == FR_DIV && w_div_done) begin
            r_cmd.bin     <= w_idx[MAX_BIN_BITS-1:0];
            r_cmd.out_idx <= w_idx[7:0];
        end
    end

    assign o_full = (r_state != FR_IDLE);
    assign o_cmd  = r_cmd;

    `HSC_ASSERT_CLK(a_add_bin_range, i_clk, i_rst_n, (r_state == FR_PUSH && r_cmd.req_type == REQ_ADD) |-> (32'(r_cmd.bin) < NB32), "add bin beyond store")
    `HSC_ASSERT_CLK(a_busy_after_beat, i_clk, i_rst_n, (i_push && !o_full) |=> o_full, "front not busy after beat")

endmodule

>>> src/hsc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsc_back
// Carries out classified requests on the bin store and accumulators.
// ----------------------------------------------------------------------------
module hsc_back #(
    parameter int NUM_BINS = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hsc_pkg::t_cmd      i_cmd,
    input  logic               i_cmd_empty,
    output logic               o_cmd_pop,
    output logic               o_res_push,
    output hsc_pkg::t_res_item o_res,
    input  logic               i_res_full
);

    `include "histogram_statistics_collector_assert.svh"
    import hsc_pkg::*;

    localparam int AW = $clog2(NUM_BINS);

    logic [31:0] r_mem [NUM_BINS];

    t_back_state r_state;
    t_back_state n_state;
    t_cmd        r_cmd;
    t_res_item   r_res;
    t_res_item   n_res;

    logic [AW-1:0] r_sweep;
    logic [31:0]   r_rd;
    logic [63:0]   r_prod;
    logic [31:0]   r_count;
    logic [63:0]   r_sum;
    logic [63:0]   r_sq;
    logic [31:0]   r_min;
    logic [31:0]   r_max;

    logic [31:0]   n_count;
    logic [63:0]   n_sum;
    logic [63:0]   n_sq;
    logic [31:0]   n_min;
    logic [31:0]   n_max;
    logic [31:0]   w_bin_inc;
    logic [64:0]   w_sum_ext;
    logic [64:0]   w_sq_ext;
    logic [63:0]   w_prod;

    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [31:0]   w_wdata;

    assign w_prod = 64'(r_cmd.sample) * 64'(r_cmd.sample);

    // request execution
    always_comb begin
        w_bin_inc = (r_rd == '1) ? r_rd : r_rd + 32'd1;
        w_sum_ext = {1'b0, r_sum} + 65'(r_cmd.sample);
        w_sq_ext  = {1'b0, r_sq} + {1'b0, r_prod};

        n_count = r_count;
        n_sum   = r_sum;
        n_sq    = r_sq;
        n_min   = r_min;
        n_max   = r_max;
        n_res.bin_index = 8'd0;
        n_res.bin_value = 32'd0;
        case (r_cmd.req_type)
            REQ_ADD: begin
                n_count = (r_count == '1) ? r_count : r_count + 32'd1;
                n_sum   = w_sum_ext[64] ? '1 : w_sum_ext[63:0];
                n_sq    = w_sq_ext[64] ? '1 : w_sq_ext[63:0];
                n_min   = (r_cmd.sample < r_min) ? r_cmd.sample : r_min;
                n_max   = (r_cmd.sample > r_max) ? r_cmd.sample : r_max;
                n_res.bin_index = r_cmd.out_idx;
                n_res.bin_value = w_bin_inc;
            end
            REQ_READ: begin
                n_res.bin_index = r_cmd.out_idx;
                n_res.bin_value = r_cmd.bin_ok ? r_rd : 32'd0;
            end
            REQ_CLEAR: begin
                n_count = '0;
                n_sum   = '0;
                n_sq    = '0;
                n_min   = '1;
                n_max   = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
        n_res.sample_count = n_count;
        n_res.value_sum    = n_sum;
        n_res.square_sum   = n_sq;
        n_res.min_value    = n_min;
        n_res.max_value    = n_max;
    end

    // sequencer and store write port
    always_comb begin
        n_state    = r_state;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        w_we       = 1'b0;
        w_waddr    = r_cmd.bin[AW-1:0];
        w_wdata    = w_bin_inc;
        case (r_state)
            BK_CLR: begin
                w_we    = 1'b1;
                w_waddr = r_sweep;
                w_wdata = '0;
                if (r_sweep == AW'(NUM_BINS - 1)) n_state = BK_IDLE;
            end
            BK_IDLE: begin
                if (!i_cmd_empty) begin
                    o_cmd_pop = 1'b1;
                    n_state   = BK_RD;
                end
            end
            BK_RD: begin
                n_state = BK_EXEC;
            end
            BK_EXEC: begin
                w_we    = (r_cmd.req_type == REQ_ADD);
                n_state = BK_OUT;
            end
            BK_OUT: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_state    = (r_cmd.req_type == REQ_CLEAR) ? BK_CLR : BK_IDLE;
                end
            end
            default: n_state = BK_CLR;
        endcase
    end

    // state, sweep counter and accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_CLR;
            r_sweep <= '0;
            r_count <= '0;
            r_sum   <= '0;
            r_sq    <= '0;
            r_min   <= '1;
            r_max   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == BK_CLR) r_sweep <= r_sweep + 1'b1;
            else                   r_sweep <= '0;
            if (r_state == BK_EXEC) begin
                r_count <= n_count;
                r_sum   <= n_sum;
                r_sq    <= n_sq;
                r_min   <= n_min;
                r_max   <= n_max;
            end
        end
    end

    // command capture, squared sample and result register
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop)             r_cmd  <= i_cmd;
        if (r_state == BK_RD)      r_prod <= w_prod;
        if (r_state == BK_EXEC)    r_res  <= n_res;
    end

    // bin store
    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) r_rd <= r_mem[i_cmd.bin[AW-1:0]];
    end

    assign o_res = r_res;

    `HSC_ASSERT_CLK(a_store_write_state, i_clk, i_rst_n, w_we |-> (r_state == BK_CLR || r_state == BK_EXEC), "bin store written outside sweep or update")
    `HSC_ASSERT_CLK(a_count_monotonic, i_clk, i_rst_n, ($past(i_rst_n) && (r_count < $past(r_count))) |-> $past(r_state == BK_EXEC && r_cmd.req_type == REQ_CLEAR), "sample count fell without a clear")

endmodule

>>> src/histogram_statistics_collector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// histogram_statistics_collector
// Histogram with running count, sum, sum of squares, minimum and maximum.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter as a queue: drive i_req and push while full is low. Each
//   request gives exactly one result, shown on o_res while empty is low and
//   taken with pop. Configuration goes through the APB-style port, registers
//   at byte addresses 0 (range start), 4 (bin width) and 8 (bins in use);
//   write it only while no request is in flight.
//   An add in range holds the front while the bit-serial divider turns the
//   sample offset into a bin number; read, clear and below-range adds skip
//   the divider. The front takes no new request until the last one is pushed
//   into the command queue, and the back takes one request at a time through
//   its read, execute and output states for the bin store read-modify-write.
//   Reset and every clear request start a sweep that zeroes the bin store,
//   one bin per cycle; requests are still accepted into the front but wait
//   for the sweep to finish.
//   A stalled receiver fills the two-entry result queue, then the back and
//   the two-entry command queue hold, and finally full stays high.
// ----------------------------------------------------------------------------
module histogram_statistics_collector #(
    parameter int NUM_BINS    = 256,
    parameter int SAMPLE_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    input  hsc_pkg::t_req_item i_req,
    output logic               full,
    input  logic               pop,
    output hsc_pkg::t_res_item o_res,
    output logic               empty,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    import hsc_pkg::*;

    t_cfg        r_cfg;
    t_cmd        w_front_cmd;
    t_cmd        w_back_cmd;
    t_res_item   w_back_res;
    logic        w_cmd_push;
    logic        w_cmd_full;
    logic        w_cmd_pop;
    logic        w_cmd_empty;
    logic        w_res_push;
    logic        w_res_full;
    logic [1:0]  w_reg_idx;
    logic        w_cfg_wr;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[3:2];
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.range_start <= 32'd0;
            r_cfg.bin_width   <= 32'd1;
            r_cfg.bins_in_use <= 9'd256;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                CFG_RANGE_START: r_cfg.range_start <= pwdata;
                CFG_BIN_WIDTH:   r_cfg.bin_width   <= pwdata;
                CFG_BINS_IN_USE: r_cfg.bins_in_use <= pwdata[8:0];
                default:         r_cfg.range_start <= r_cfg.range_start;
            endcase
        end
    end

    // register read-back
    always_comb begin
        case (w_reg_idx)
            CFG_RANGE_START: prdata = r_cfg.range_start;
            CFG_BIN_WIDTH:   prdata = r_cfg.bin_width;
            CFG_BINS_IN_USE: prdata = 32'(r_cfg.bins_in_use);
            default:         prdata = 32'd0;
        endcase
    end

    hsc_front #(
        .NUM_BINS    (NUM_BINS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_push     (push),
        .i_req      (i_req),
        .o_full     (full),
        .o_cmd_push (w_cmd_push),
        .o_cmd      (w_front_cmd),
        .i_cmd_full (w_cmd_full)
    );

    hsc_fifo #(
        .W ($bits(t_cmd))
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_din   (w_front_cmd),
        .o_full  (w_cmd_full),
        .i_pop   (w_cmd_pop),
        .o_dout  (w_back_cmd),
        .o_empty (w_cmd_empty)
    );

    hsc_back #(
        .NUM_BINS (NUM_BINS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_back_cmd),
        .i_cmd_empty (w_cmd_empty),
        .o_cmd_pop   (w_cmd_pop),
        .o_res_push  (w_res_push),
        .o_res       (w_back_res),
        .i_res_full  (w_res_full)
    );

    hsc_fifo #(
        .W ($bits(t_res_item))
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_din   (w_back_res),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_dout  (o_res),
        .o_empty (empty)
    );

endmodule
